// ===== rtl/core/ccmm_pkg.sv =====
// Shared constants, codes and types of the cross-check match minima core.
package ccmm_pkg;

  localparam int unsigned MAX_COLS   = 1024;
  localparam int unsigned MAX_ROWS   = 4096;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned CFG_COLS_W = 11;
  localparam int unsigned CFG_ROWS_W = 13;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = 3;
  localparam int unsigned FIFO_CNT_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS_IN_USE = 1'b0,
    CFG_ROWS_IN_USE = 1'b1
  } cfg_reg_e;

  localparam logic KIND_ROW    = 1'b0;
  localparam logic KIND_COLUMN = 1'b1;

  typedef struct packed {
    logic                      kind;
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic signed [VALUE_W-1:0] min_dist;
    logic                      last;
  } result_t;

endpackage

// ===== rtl/core/ccmm_if.sv =====
// Stream interfaces for matrix elements in and match results out.
interface ccmm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ccmm_pkg::VALUE_W-1:0] distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

interface ccmm_out_if;
  logic                                valid;
  logic                                ready;
  logic                                result_kind;
  logic [ccmm_pkg::ROW_W-1:0]          row_number;
  logic [ccmm_pkg::COL_W-1:0]          column_number;
  logic signed [ccmm_pkg::VALUE_W-1:0] min_distance;
  logic                                last_of_run;

  modport source (output valid, output result_kind, output row_number,
                  output column_number, output min_distance, output last_of_run,
                  input ready);
  modport sink   (input valid, input result_kind, input row_number,
                  input column_number, input min_distance, input last_of_run,
                  output ready);
endinterface

// ===== rtl/core/ccmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ccmm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/cross_check_match_minima_core.sv =====
// Cross-check match minima core: row argmin and column minima over a streamed matrix.
//
// Matrix elements arrive one per transaction in row-major order; the block takes one
// element every clock cycle unless stalled. The element's column entry is read from a
// 1024 x 32 column-minimum memory at the accept edge and compared and written back in
// the next cycle, with a bypass for back-to-back hits on the same column, so results
// enter an eight-entry output queue in the cycle after acceptance and can leave in
// the cycle after that. Each element yields zero, one or two results (a column minimum
// on every element of the last row, a row best match on the last element of each row;
// ties in a row go to the later column). The output leaves at one result per cycle
// while the sink is ready; input stalls only while the queue lacks room for two
// results of the element in flight and two of the next. The column memory needs no
// clearing after reset: the first row of each matrix writes every entry it later reads.
// Write cols_in_use and rows_in_use only while no element is in flight.
module cross_check_match_minima_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ccmm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ccmm_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  ccmm_in_if.sink                              in_i,
  ccmm_out_if.source                           out_o
);

  // configuration
  logic [ccmm_pkg::CFG_COLS_W-1:0] cols_q;
  logic [ccmm_pkg::CFG_ROWS_W-1:0] rows_q;
  logic [ccmm_pkg::CFG_COLS_W-1:0] ncols;
  logic [ccmm_pkg::CFG_ROWS_W-1:0] nrows;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= ccmm_pkg::CFG_COLS_W'(ccmm_pkg::MAX_COLS);
      rows_q <= ccmm_pkg::CFG_ROWS_W'(ccmm_pkg::MAX_ROWS);
    end else if (cfg_we_i) begin
      unique case (ccmm_pkg::cfg_reg_e'(cfg_idx_i))
        ccmm_pkg::CFG_COLS_IN_USE: cols_q <= cfg_wdata_i[ccmm_pkg::CFG_COLS_W-1:0];
        ccmm_pkg::CFG_ROWS_IN_USE: rows_q <= cfg_wdata_i[ccmm_pkg::CFG_ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize saturates
  always_comb begin
    if (cols_q == '0) begin
      ncols = ccmm_pkg::CFG_COLS_W'(1);
    end else if (cols_q > ccmm_pkg::CFG_COLS_W'(ccmm_pkg::MAX_COLS)) begin
      ncols = ccmm_pkg::CFG_COLS_W'(ccmm_pkg::MAX_COLS);
    end else begin
      ncols = cols_q;
    end
    if (rows_q == '0) begin
      nrows = ccmm_pkg::CFG_ROWS_W'(1);
    end else if (rows_q > ccmm_pkg::CFG_ROWS_W'(ccmm_pkg::MAX_ROWS)) begin
      nrows = ccmm_pkg::CFG_ROWS_W'(ccmm_pkg::MAX_ROWS);
    end else begin
      nrows = rows_q;
    end
  end

  // position counters
  logic [ccmm_pkg::COL_W-1:0] col_q;
  logic [ccmm_pkg::ROW_W-1:0] row_q;
  logic                       in_row_end;
  logic                       in_last_row;
  logic                       in_accept;

  assign in_row_end  = ({1'b0, col_q} + ccmm_pkg::CFG_COLS_W'(1)) >= ncols;
  assign in_last_row = ({1'b0, row_q} + ccmm_pkg::CFG_ROWS_W'(1)) >= nrows;
  assign in_accept   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_accept) begin
      if (in_row_end) begin
        col_q <= '0;
        row_q <= in_last_row ? '0 : row_q + ccmm_pkg::ROW_W'(1);
      end else begin
        col_q <= col_q + ccmm_pkg::COL_W'(1);
      end
    end
  end

  // compare stage
  logic                                s1_valid_q;
  logic signed [ccmm_pkg::VALUE_W-1:0] s1_dist_q;
  logic [ccmm_pkg::COL_W-1:0]          s1_col_q;
  logic [ccmm_pkg::ROW_W-1:0]          s1_row_q;
  logic                                s1_row_end_q;
  logic                                s1_last_row_q;
  logic                                fwd_q;
  logic signed [ccmm_pkg::VALUE_W-1:0] fwd_data_q;
  logic signed [ccmm_pkg::VALUE_W-1:0] rmin_q;
  logic [ccmm_pkg::COL_W-1:0]          rarg_q;

  logic [ccmm_pkg::VALUE_W-1:0]        ram_rdata;
  logic signed [ccmm_pkg::VALUE_W-1:0] cmin_old;
  logic signed [ccmm_pkg::VALUE_W-1:0] cmin_new;
  logic signed [ccmm_pkg::VALUE_W-1:0] rmin_new;
  logic [ccmm_pkg::COL_W-1:0]          rarg_new;

  ccmm_ram #(
    .WIDTH (ccmm_pkg::VALUE_W),
    .DEPTH (ccmm_pkg::MAX_COLS)
  ) u_col_mem (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (cmin_new),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    // take the value written at the accept edge when it hit the same column
    cmin_old = fwd_q ? fwd_data_q : $signed(ram_rdata);
    if (s1_row_q == '0 || s1_dist_q < cmin_old) begin
      cmin_new = s1_dist_q;
    end else begin
      cmin_new = cmin_old;
    end
    // ties move to the later column
    if (s1_col_q == '0 || s1_dist_q <= rmin_q) begin
      rmin_new = s1_dist_q;
      rarg_new = s1_col_q;
    end else begin
      rmin_new = rmin_q;
      rarg_new = rarg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      rmin_q     <= '0;
      rarg_q     <= '0;
    end else begin
      s1_valid_q <= in_accept;
      fwd_q      <= in_accept && s1_valid_q && (s1_col_q == col_q);
      if (s1_valid_q) begin
        rmin_q <= rmin_new;
        rarg_q <= rarg_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= cmin_new;
    if (in_accept) begin
      s1_dist_q     <= in_i.distance;
      s1_col_q      <= col_q;
      s1_row_q      <= row_q;
      s1_row_end_q  <= in_row_end;
      s1_last_row_q <= in_last_row;
    end
  end

  // output queue
  ccmm_pkg::result_t                fifo_q [ccmm_pkg::FIFO_DEPTH];
  logic [ccmm_pkg::FIFO_PTR_W-1:0]  wr_ptr_q;
  logic [ccmm_pkg::FIFO_PTR_W-1:0]  rd_ptr_q;
  logic [ccmm_pkg::FIFO_CNT_W-1:0]  count_q;
  logic [ccmm_pkg::FIFO_CNT_W-1:0]  n_push;
  logic                             pop;
  ccmm_pkg::result_t                res_col;
  ccmm_pkg::result_t                res_row;
  ccmm_pkg::result_t                res_first;
  ccmm_pkg::result_t                head;

  always_comb begin
    res_col = '{kind: ccmm_pkg::KIND_COLUMN, row: s1_row_q, col: s1_col_q,
                min_dist: cmin_new, last: !s1_row_end_q};
    res_row = '{kind: ccmm_pkg::KIND_ROW, row: s1_row_q, col: rarg_new,
                min_dist: rmin_new, last: 1'b1};
    res_first = s1_last_row_q ? res_col : res_row;
    n_push = s1_valid_q
           ? ccmm_pkg::FIFO_CNT_W'(s1_last_row_q) + ccmm_pkg::FIFO_CNT_W'(s1_row_end_q)
           : '0;
  end

  assign pop  = out_o.valid && out_o.ready;
  assign head = fifo_q[rd_ptr_q];

  // leave room for two results of the element in flight and two of the next
  assign in_i.ready = (count_q + {s1_valid_q, 1'b0})
                      <= ccmm_pkg::FIFO_CNT_W'(ccmm_pkg::FIFO_DEPTH - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + n_push[ccmm_pkg::FIFO_PTR_W-1:0];
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + ccmm_pkg::FIFO_PTR_W'(1);
      end
      count_q <= count_q + n_push - ccmm_pkg::FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != '0) begin
      fifo_q[wr_ptr_q] <= res_first;
    end
    if (n_push == ccmm_pkg::FIFO_CNT_W'(2)) begin
      fifo_q[wr_ptr_q + ccmm_pkg::FIFO_PTR_W'(1)] <= res_row;
    end
  end

  assign out_o.valid         = count_q != '0;
  assign out_o.result_kind   = head.kind;
  assign out_o.row_number    = head.row;
  assign out_o.column_number = head.col;
  assign out_o.min_distance  = head.min_dist;
  assign out_o.last_of_run   = head.last;

  // checks
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ccmm_pkg::FIFO_CNT_W'(ccmm_pkg::FIFO_DEPTH))
    else $error("output queue overflow");

  a_accept_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted element did not reach compare stage");

  a_fwd_only_after_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q && $past(s1_valid_q))
    else $error("bypass without a preceding write");

  a_row_result_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.result_kind == ccmm_pkg::KIND_ROW) |-> out_o.last_of_run)
    else $error("row result not marked last of run");

endmodule
